// ===== rtl/core/rfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types, constants and pattern tables for the radar frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

    // payload store bound and derived widths
    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

    // output field widths
    localparam int IDX_W   = 6;
    localparam int LEN_W   = 7;
    localparam int TDATA_W = 24;

    // frame kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_ACK    = 1'b1;

    // header and trailer bytes
    localparam logic [7:0] HDR_RPT_0 = 8'hF4;
    localparam logic [7:0] HDR_RPT_1 = 8'hF3;
    localparam logic [7:0] HDR_RPT_2 = 8'hF2;
    localparam logic [7:0] HDR_RPT_3 = 8'hF1;
    localparam logic [7:0] HDR_ACK_0 = 8'hFD;
    localparam logic [7:0] HDR_ACK_1 = 8'hFC;
    localparam logic [7:0] HDR_ACK_2 = 8'hFB;
    localparam logic [7:0] HDR_ACK_3 = 8'hFA;
    localparam logic [7:0] TRL_RPT_0 = 8'hF8;
    localparam logic [7:0] TRL_RPT_1 = 8'hF7;
    localparam logic [7:0] TRL_RPT_2 = 8'hF6;
    localparam logic [7:0] TRL_RPT_3 = 8'hF5;
    localparam logic [7:0] TRL_ACK_0 = 8'h04;
    localparam logic [7:0] TRL_ACK_1 = 8'h03;
    localparam logic [7:0] TRL_ACK_2 = 8'h02;
    localparam logic [7:0] TRL_ACK_3 = 8'h01;

    // write request into the payload store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

    // frame accepted on a good trailer
    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [LEN_W-1:0] length;
    } t_frame_done;

    function automatic logic [7:0] head_byte(input logic kind, input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0:    b = (kind == KIND_ACK) ? HDR_ACK_0 : HDR_RPT_0;
            2'd1:    b = (kind == KIND_ACK) ? HDR_ACK_1 : HDR_RPT_1;
            2'd2:    b = (kind == KIND_ACK) ? HDR_ACK_2 : HDR_RPT_2;
            default: b = (kind == KIND_ACK) ? HDR_ACK_3 : HDR_RPT_3;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tail_byte(input logic kind, input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0:    b = (kind == KIND_ACK) ? TRL_ACK_0 : TRL_RPT_0;
            2'd1:    b = (kind == KIND_ACK) ? TRL_ACK_1 : TRL_RPT_1;
            2'd2:    b = (kind == KIND_ACK) ? TRL_ACK_2 : TRL_RPT_2;
            default: b = (kind == KIND_ACK) ? TRL_ACK_3 : TRL_RPT_3;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/radar_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// radar_frame_deframer
// Deframes header / length / payload / trailer frames from a serial byte
// stream and replays the payload of each good frame from a byte store.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                                  tuser / tlast
//  s_axis    in         rx_byte[7:0]                           -
//  m_axis    out        payload_byte, byte_index, payload_len  frame_kind / last
//
//  while parsing, one received byte is taken every cycle.
//  after a good trailer, input stalls while the payload is read back from the
//  64-byte store (one registered read port): with the sink always ready,
//  one payload byte a cycle.
//  input reopens as soon as the final byte sits in the output register.
//  reset is synchronous and clears control state; the store is not cleared.
//  a stalled sink holds the output register and pauses store reads.
// ----------------------------------------------------------------------------
module radar_frame_deframer import rfd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [7:0] payload_byte, [13:8] byte_index,
                                               // [20:14] payload_length, [23:21] zero
    output logic               m_axis_tlast,
    output logic               m_axis_tuser    // [0] frame_kind
);

    localparam logic MODE_PARSE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    t_store_wr   wr;
    t_frame_done done;

    logic              byte_req;
    logic              out_free;
    logic              rd_issue;
    logic              rd_load;
    logic              pend_last;

    logic [7:0]        r_mem [MAX_PAYLOAD];
    logic [7:0]        r_mem_q;

    logic              r_mode, n_mode;
    logic              r_kind, n_kind;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_issue, n_issue;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pend_idx, n_pend_idx;

    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte;
    logic [IDX_W-1:0]  r_out_idx;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_last;
    logic              r_out_kind;

    assign s_axis_tready = (r_mode == MODE_PARSE);
    assign byte_req      = s_axis_tvalid && s_axis_tready;

    rfd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_req (byte_req),
        .i_byte     (s_axis_tdata),
        .o_wr       (wr),
        .o_done     (done)
    );

    // payload store: one write port from the parser, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr.en) begin
            r_mem[wr.addr] <= wr.data;
        end
        if (rd_issue) begin
            r_mem_q <= r_mem[r_issue[ADDR_W-1:0]];
        end
    end

    assign out_free  = !r_out_valid || m_axis_tready;
    assign rd_load   = r_pend && out_free;
    assign rd_issue  = (r_mode == MODE_READ) && (r_issue < CNT_W'(r_len))
                       && (!r_pend || out_free);
    assign pend_last = (CNT_W'(r_pend_idx) + CNT_W'(1)) == CNT_W'(r_len);

    always_comb begin
        n_mode      = r_mode;
        n_kind      = r_kind;
        n_len       = r_len;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_out_valid = r_out_valid;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (rd_load) begin
            n_out_valid = 1'b1;
            n_pend      = 1'b0;
            if (pend_last) begin
                n_mode = MODE_PARSE;
            end
        end
        if (rd_issue) begin
            n_pend     = 1'b1;
            n_pend_idx = r_issue[ADDR_W-1:0];
            n_issue    = r_issue + CNT_W'(1);
        end
        if (done.valid) begin
            n_mode  = MODE_READ;
            n_kind  = done.kind;
            n_len   = done.length;
            n_issue = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_PARSE;
            r_kind      <= KIND_REPORT;
            r_len       <= '0;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_pend_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_kind      <= n_kind;
            r_len       <= n_len;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_pend_idx  <= n_pend_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_load) begin
            r_out_byte <= r_mem_q;
            r_out_idx  <= IDX_W'(r_pend_idx);
            r_out_len  <= r_len;
            r_out_last <= pend_last;
            r_out_kind <= r_kind;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_len, r_out_idx, r_out_byte};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_kind;

endmodule

// ===== rtl/core/rfd_parser.sv =====
// ----------------------------------------------------------------------------
// rfd_parser
// Header hunt, length capture, payload store writes and trailer check.
// ----------------------------------------------------------------------------
module rfd_parser import rfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_req,
    input  logic [7:0]  i_byte,
    output t_store_wr   o_wr,
    output t_frame_done o_done
);

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LEN_LO = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_TRAIL  = 3'd4;

    logic [2:0]       r_phase, n_phase;
    logic [1:0]       r_match, n_match;
    logic             r_kind, n_kind;
    logic [7:0]       r_len_lo, n_len_lo;
    logic [LEN_W-1:0] r_length, n_length;
    logic [CNT_W-1:0] r_count, n_count;

    logic [15:0]      len_full;
    logic [CNT_W-1:0] count_inc;

    assign len_full  = {i_byte, r_len_lo};
    assign count_inc = r_count + CNT_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_match  = r_match;
        n_kind   = r_kind;
        n_len_lo = r_len_lo;
        n_length = r_length;
        n_count  = r_count;
        o_wr     = '0;
        o_done   = '0;
        if (i_byte_req) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (r_match != 2'd0 && i_byte == head_byte(r_kind, r_match)) begin
                        if (r_match == 2'd3) begin
                            n_match = 2'd0;
                            n_phase = PH_LEN_LO;
                        end else begin
                            n_match = r_match + 2'd1;
                        end
                    end else begin
                        // restart the match, the byte itself may open a header
                        priority if (i_byte == HDR_RPT_0) begin
                            n_kind  = KIND_REPORT;
                            n_match = 2'd1;
                        end else if (i_byte == HDR_ACK_0) begin
                            n_kind  = KIND_ACK;
                            n_match = 2'd1;
                        end else begin
                            n_match = 2'd0;
                        end
                    end
                end
                PH_LEN_LO: begin
                    n_len_lo = i_byte;
                    n_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    if (len_full == 16'd0 || len_full > 16'(MAX_PAYLOAD)) begin
                        n_phase = PH_HUNT;
                        n_match = 2'd0;
                    end else begin
                        n_length = len_full[LEN_W-1:0];
                        n_count  = '0;
                        n_phase  = PH_DATA;
                    end
                end
                PH_DATA: begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_count[ADDR_W-1:0];
                    o_wr.data = i_byte;
                    n_count   = count_inc;
                    if (count_inc >= CNT_W'(r_length)) begin
                        n_match = 2'd0;
                        n_phase = PH_TRAIL;
                    end
                end
                PH_TRAIL: begin
                    n_match = 2'd0;
                    n_phase = PH_HUNT;
                    if (i_byte == tail_byte(r_kind, r_match)) begin
                        if (r_match == 2'd3) begin
                            o_done.valid  = 1'b1;
                            o_done.kind   = r_kind;
                            o_done.length = r_length;
                        end else begin
                            n_match = r_match + 2'd1;
                            n_phase = PH_TRAIL;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_match = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_match  <= 2'd0;
            r_kind   <= KIND_REPORT;
            r_len_lo <= 8'd0;
            r_length <= '0;
            r_count  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_kind   <= n_kind;
            r_len_lo <= n_len_lo;
            r_length <= n_length;
            r_count  <= n_count;
        end
    end

endmodule
